// ----- rtl/core/cva_pkg.sv -----
// cva_pkg: shared types and constants for the channel value adjuster
// holds payload structs, register indexes, mode codes and sizing constants
// no dependencies
package cva_pkg;

    // channel and counter sizing
    localparam logic [16:0] MAX_CHANNELS = 17'd65536;
    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam logic [17:0] NEXT_MAX     = 18'h3FFFF;

    // divide by 100 through a scaled reciprocal, exact for products below 2^18
    localparam logic [18:0] PCT_RECIP = 19'd335545;
    localparam int          PCT_SHIFT = 25;

    // configuration register indexes
    localparam logic [2:0] CFG_ACTION_MODE    = 3'd0;
    localparam logic [2:0] CFG_FIRST_VALUE    = 3'd1;
    localparam logic [2:0] CFG_SECOND_VALUE   = 3'd2;
    localparam logic [2:0] CFG_CHANNEL_STRIDE = 3'd3;
    localparam logic [2:0] CFG_FIRST_CHANNEL  = 3'd4;
    localparam logic [2:0] CFG_MAX_ADJUSTED   = 3'd5;
    localparam logic [2:0] CFG_CHANNEL_LIMIT  = 3'd6;
    localparam logic [2:0] CFG_SINGLE_COLOUR  = 3'd7;

    // action modes
    localparam logic [3:0] MODE_NONE         = 4'd0;
    localparam logic [3:0] MODE_ADD          = 4'd1;
    localparam logic [3:0] MODE_PERCENT      = 4'd2;
    localparam logic [3:0] MODE_FLOOR        = 4'd3;
    localparam logic [3:0] MODE_CEILING      = 4'd4;
    localparam logic [3:0] MODE_RANGE        = 4'd5;
    localparam logic [3:0] MODE_WRAP_ADD     = 4'd6;
    localparam logic [3:0] MODE_WRAP_PERCENT = 4'd7;
    localparam logic [3:0] MODE_AVOID_RANGE  = 4'd8;
    localparam logic [3:0] MODE_INVERT       = 4'd9;

    typedef struct packed {
        logic [7:0] chan_value;
        logic       frame_last;
    } cva_in_t;

    typedef struct packed {
        logic [7:0] out_value;
        logic       was_adjusted;
        logic       fill_all_colours;
    } cva_out_t;

endpackage

// ----- rtl/core/channel_value_adjuster.sv -----
// channel_value_adjuster: selects channels of a frame and runs them through a mode datapath
// throughput: one item per cycle unless m_ready stalls the result register
// stages: selection and percent product into an input register, then divide, mode, clamp
// reset (aresetn, synchronous, active low): counters cleared, registers to defaults
// depends on cva_pkg
module channel_value_adjuster (
    input  logic             aclk,
    input  logic             aresetn,
    // item input
    input  logic             s_valid,
    output logic             s_ready,
    input  cva_pkg::cva_in_t s_data,
    // result output
    output logic             m_valid,
    input  logic             m_ready,
    output cva_pkg::cva_out_t m_data,
    // configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [16:0]      cfg_data
);
    import cva_pkg::*;

    // configuration registers
    logic [3:0]         mode_reg;
    logic signed [10:0] first_val_reg;
    logic signed [10:0] second_val_reg;
    logic [16:0]        stride_reg;
    logic [16:0]        first_chan_reg;
    logic [16:0]        max_adj_reg;
    logic [16:0]        limit_reg;
    logic               single_reg;

    // frame counters
    logic [16:0] pos_reg,  pos_next;
    logic [17:0] next_sel_reg, next_sel_next;
    logic [16:0] cnt_reg,  cnt_next;

    // input stage
    logic        a_vld_reg;
    logic [7:0]  a_val_reg;
    logic        a_sel_reg;
    logic        a_fill_reg;
    logic [17:0] a_prod_reg;

    // result register
    logic     m_vld_reg;
    cva_out_t m_data_reg;

    // handshake
    logic accept;
    logic out_adv;
    logic cfg_write;

    // selection
    logic [16:0] limit_eff;
    logic [16:0] stride_eff;
    logic [17:0] start_idx;
    logic [18:0] next_sum;
    logic        sel;

    // percent product
    logic [10:0] abs_first;
    logic [17:0] pct_prod;

    // result datapath
    logic [36:0]        recip_prod;
    logic [11:0]        pct_quot;
    logic signed [12:0] v_s;
    logic signed [12:0] fa_s;
    logic signed [12:0] fb_s;
    logic signed [12:0] lo_s;
    logic signed [12:0] hi_s;
    logic signed [12:0] sum_s;
    logic signed [12:0] res_s;
    logic [7:0]         adj_val;

    // output register frees when empty or being taken
    assign out_adv   = !m_vld_reg || m_ready;
    // input stage takes an item when empty or when it moves on this cycle
    assign s_ready   = !a_vld_reg || out_adv;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    // ---------------- selection ----------------

    // usable channel count capped at the channel maximum
    assign limit_eff  = (limit_reg > MAX_CHANNELS) ? MAX_CHANNELS : limit_reg;
    // zero stride behaves as one
    assign stride_eff = (stride_reg == 17'd0) ? 17'd1 : stride_reg;
    // zero-based start position, zero first channel behaves as one
    assign start_idx  = (first_chan_reg == 17'd0) ? 18'd0
                                                  : {1'b0, first_chan_reg - 17'd1};
    assign next_sum   = {1'b0, next_sel_reg} + {2'b00, stride_eff};

    assign sel = ({1'b0, pos_reg} == next_sel_reg) && (pos_reg < limit_eff) &&
                 ((max_adj_reg == 17'd0) || (cnt_reg < max_adj_reg));

    // counter update per accepted item
    always_comb begin
        pos_next      = pos_reg;
        next_sel_next = next_sel_reg;
        cnt_next      = cnt_reg;
        if (accept) begin
            if (sel) begin
                // saturate so a frame without an end never selects twice
                next_sel_next = (next_sum > {1'b0, NEXT_MAX}) ? NEXT_MAX : next_sum[17:0];
                if (cnt_reg < POS_MAX) begin
                    cnt_next = cnt_reg + 17'd1;
                end
            end
            if (s_data.frame_last) begin
                pos_next      = '0;
                next_sel_next = start_idx;
                cnt_next      = '0;
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 17'd1;
            end
        end else if (cfg_write && cfg_index == CFG_FIRST_CHANNEL && pos_reg == 17'd0) begin
            // new start position takes effect at once only before the frame begins
            next_sel_next = (cfg_data == 17'd0) ? 18'd0 : {1'b0, cfg_data - 17'd1};
        end
    end

    // magnitude of the percent product, sign follows first_value
    assign abs_first = first_val_reg[10] ? (11'd0 - first_val_reg) : first_val_reg;
    assign pct_prod  = 18'(s_data.chan_value) * 18'(abs_first);

    // ---------------- configuration and counters ----------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NONE;
            first_val_reg  <= '0;
            second_val_reg <= '0;
            stride_reg     <= 17'd1;
            first_chan_reg <= 17'd1;
            max_adj_reg    <= '0;
            limit_reg      <= MAX_CHANNELS;
            single_reg     <= 1'b0;
            pos_reg        <= '0;
            next_sel_reg   <= '0;
            cnt_reg        <= '0;
        end else begin
            pos_reg      <= pos_next;
            next_sel_reg <= next_sel_next;
            cnt_reg      <= cnt_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_ACTION_MODE:    mode_reg       <= cfg_data[3:0];
                    CFG_FIRST_VALUE:    first_val_reg  <= cfg_data[10:0];
                    CFG_SECOND_VALUE:   second_val_reg <= cfg_data[10:0];
                    CFG_CHANNEL_STRIDE: stride_reg     <= cfg_data;
                    CFG_FIRST_CHANNEL:  first_chan_reg <= cfg_data;
                    CFG_MAX_ADJUSTED:   max_adj_reg    <= cfg_data;
                    CFG_CHANNEL_LIMIT:  limit_reg      <= cfg_data;
                    CFG_SINGLE_COLOUR:  single_reg     <= cfg_data[0];
                endcase
            end
        end
    end

    // ---------------- input stage ----------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (accept) begin
            a_vld_reg <= 1'b1;
        end else if (out_adv) begin
            a_vld_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_val_reg  <= s_data.chan_value;
            a_sel_reg  <= sel;
            a_fill_reg <= sel && single_reg;
            a_prod_reg <= pct_prod;
        end
    end

    // ---------------- mode datapath ----------------

    // divide the percent product by 100, truncated
    assign recip_prod = 37'(a_prod_reg) * 37'(PCT_RECIP);
    assign pct_quot   = recip_prod[PCT_SHIFT +: 12];

    assign v_s  = $signed({5'b00000, a_val_reg});
    assign fa_s = 13'(first_val_reg);
    assign fb_s = 13'(second_val_reg);
    // bounds in order
    assign lo_s = (fa_s > fb_s) ? fb_s : fa_s;
    assign hi_s = (fa_s > fb_s) ? fa_s : fb_s;
    assign sum_s = v_s + fa_s;

    always_comb begin
        res_s = v_s;
        unique case (mode_reg)
            MODE_ADD: begin
                res_s = sum_s;
            end
            MODE_PERCENT: begin
                res_s = first_val_reg[10] ? (v_s - $signed({1'b0, pct_quot}))
                                          : (v_s + $signed({1'b0, pct_quot}));
            end
            MODE_FLOOR: begin
                res_s = (fa_s > v_s) ? fa_s : v_s;
            end
            MODE_CEILING: begin
                res_s = (fa_s < v_s) ? fa_s : v_s;
            end
            MODE_RANGE: begin
                if (v_s < lo_s) begin
                    res_s = lo_s;
                end else if (v_s > hi_s) begin
                    res_s = hi_s;
                end
            end
            MODE_WRAP_ADD: begin
                // a single wrap by 256 either way
                if (sum_s < 13'sd0) begin
                    res_s = sum_s + 13'sd256;
                end else if (sum_s > 13'sd255) begin
                    res_s = sum_s - 13'sd256;
                end else begin
                    res_s = sum_s;
                end
            end
            MODE_AVOID_RANGE: begin
                // snap to nearer bound, upper on a tie
                if (v_s >= lo_s && v_s <= hi_s) begin
                    res_s = ((v_s - lo_s) < (hi_s - v_s)) ? lo_s : hi_s;
                end
            end
            MODE_INVERT: begin
                res_s = 13'sd255 - v_s;
            end
            default: begin
                // none, wrap percent and unused codes pass through
                res_s = v_s;
            end
        endcase
    end

    // clamp to a byte
    assign adj_val = (res_s < 13'sd0)   ? 8'd0   :
                     (res_s > 13'sd255) ? 8'd255 : res_s[7:0];

    // ---------------- result register ----------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_adv) begin
            m_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && a_vld_reg) begin
            m_data_reg.out_value        <= a_sel_reg ? adj_val : a_val_reg;
            m_data_reg.was_adjusted     <= a_sel_reg;
            m_data_reg.fill_all_colours <= a_fill_reg;
        end
    end

`ifndef ASSERT_OFF
    // colour fill only on adjusted channels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg |-> (!m_data_reg.fill_all_colours || m_data_reg.was_adjusted))
        else $error("fill_all_colours without was_adjusted");

    // an empty result register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_vld_reg |-> s_ready)
        else $error("input stalled with empty result register");

    // a held item in the input stage is not dropped while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_vld_reg && m_vld_reg && !m_ready) |=> a_vld_reg)
        else $error("input stage item lost under stall");

    // frame end restarts the position counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.frame_last) |=> (pos_reg == 17'd0 && cnt_reg == 17'd0))
        else $error("counters not cleared after frame end");
`endif

endmodule

// ----- tb/tb_channel_value_adjuster.sv -----
// tb_channel_value_adjuster: self-checking bench for the channel value adjuster
// predicts every result from its own copy of registers and frame counters, randomizes both sides
// depends on cva_pkg and channel_value_adjuster
module tb_channel_value_adjuster;
    timeunit 1ns;
    timeprecision 1ps;

    import cva_pkg::*;

    // highest mode code, everything above invert behaves as none
    localparam logic [3:0] MODE_LAST_CODE = 4'hF;

    logic aclk = 1'b0;
    logic aresetn;

    logic        s_valid;
    logic        s_ready;
    cva_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    cva_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // predictor copy of the registers
    logic [3:0]         reg_mode;
    logic signed [10:0] reg_first_val;
    logic signed [10:0] reg_second_val;
    logic [16:0]        reg_stride;
    logic [16:0]        reg_first;
    logic [16:0]        reg_cap;
    logic [16:0]        reg_limit;
    logic               reg_single;

    // predictor copy of the frame counters
    logic [16:0] chan_pos;
    logic [17:0] next_pick;
    logic [16:0] adj_count;

    // results still owed by the block, oldest first
    cva_out_t expected_adjustments[$];

    int error_count = 0;
    int send_gap_max = 13;     // sender idle cycles drawn per item from 0 up to this
    int sink_gap_max = 13;     // receiver stall cycles drawn per result from 0 up to this
    int hold_request = 0;      // long receiver hold-off, picked up by the sink process

    always #6 aclk = ~aclk;

    channel_value_adjuster u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // zero-based position of the first adjusted channel, first channel 0 acts as 1
    function automatic logic [17:0] start_pick();
        return (reg_first == '0) ? 18'd0 : ({1'b0, reg_first} - 18'd1);
    endfunction

    // mode datapath on one channel byte, result clamped to a byte
    function automatic logic [7:0] mode_value(logic [7:0] v);
        int x;
        int a;
        int b;
        int t;
        x = v;
        a = reg_first_val;
        b = reg_second_val;
        case (reg_mode)
            MODE_ADD: begin
                x = x + a;
            end
            MODE_PERCENT: begin
                // integer division truncates toward zero
                x = x + (x * a) / 100;
            end
            MODE_FLOOR: begin
                if (a > x) x = a;
            end
            MODE_CEILING: begin
                if (a < x) x = a;
            end
            MODE_RANGE: begin
                if (a > b) begin t = a; a = b; b = t; end
                if (x < a) x = a;
                if (x > b) x = b;
            end
            MODE_WRAP_ADD: begin
                // a single wrap only, anything further is clamped below
                x = x + a;
                if (x < 0) x = x + 256;
                else if (x > 255) x = x - 256;
            end
            MODE_AVOID_RANGE: begin
                if (a > b) begin t = a; a = b; b = t; end
                // snap to the nearer bound, the upper one on a tie
                if (x >= a && x <= b) x = (x - a < b - x) ? a : b;
            end
            MODE_INVERT: begin
                x = 255 - x;
            end
            default: begin
                // none, wrap by percentage and unused codes pass the byte through
            end
        endcase
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return x[7:0];
    endfunction

    // expected result of one accepted channel, advances the frame counters
    function automatic cva_out_t predict_adjustment(cva_in_t item);
        cva_out_t    res;
        logic [16:0] lim;
        logic [17:0] stride;
        logic [18:0] advanced;
        logic        pick;
        lim    = (reg_limit > MAX_CHANNELS) ? MAX_CHANNELS : reg_limit;
        stride = (reg_stride == '0) ? 18'd1 : {1'b0, reg_stride};
        pick   = ({1'b0, chan_pos} == next_pick) && (chan_pos < lim) &&
                 (reg_cap == '0 || adj_count < reg_cap);
        res.out_value = item.chan_value;
        if (pick) begin
            res.out_value = mode_value(item.chan_value);
            advanced  = next_pick + stride;
            next_pick = (advanced > NEXT_MAX) ? NEXT_MAX : advanced[17:0];
            if (adj_count < POS_MAX) adj_count = adj_count + 17'd1;
        end
        res.was_adjusted     = pick;
        res.fill_all_colours = pick && reg_single;
        if (item.frame_last) begin
            chan_pos  = '0;
            next_pick = start_pick();
            adj_count = '0;
        end else if (chan_pos < POS_MAX) begin
            chan_pos = chan_pos + 17'd1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // offer one channel byte, valid stays up afterwards unless the next item idles first
    task automatic offer_channel(logic [7:0] value, logic last);
        int      gap;
        cva_in_t item;
        gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
        item.chan_value = value;
        item.frame_last = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_adjustments = {expected_adjustments, predict_adjustment(item)};
    endtask

    // drop valid and let every owed result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_adjustments.size() != 0) @(posedge aclk);
        // a little slack after the last result is taken
        repeat (4) @(posedge aclk);
    endtask

    // one register write, valid stays up so back-to-back writes need no gap
    task automatic cfg_write(logic [2:0] idx, logic [16:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ACTION_MODE:    reg_mode       = data[3:0];
            CFG_FIRST_VALUE:    reg_first_val  = data[10:0];
            CFG_SECOND_VALUE:   reg_second_val = data[10:0];
            CFG_CHANNEL_STRIDE: reg_stride     = data;
            CFG_FIRST_CHANNEL: begin
                reg_first = data;
                // only a frame that has not started picks up the new start
                if (chan_pos == '0) next_pick = start_pick();
            end
            CFG_MAX_ADJUSTED:   reg_cap        = data;
            CFG_CHANNEL_LIMIT:  reg_limit      = data;
            CFG_SINGLE_COLOUR:  reg_single     = data[0];
            default: begin
            end
        endcase
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // write all eight registers, block must be idle
    task automatic load_settings(logic [3:0] mode, int lo, int hi, logic [16:0] stride,
                                 logic [16:0] first, logic [16:0] cap, logic [16:0] limit,
                                 logic single);
        cfg_write(CFG_ACTION_MODE, {13'd0, mode});
        cfg_write(CFG_FIRST_VALUE, {6'd0, lo[10:0]});
        cfg_write(CFG_SECOND_VALUE, {6'd0, hi[10:0]});
        cfg_write(CFG_CHANNEL_STRIDE, stride);
        cfg_write(CFG_FIRST_CHANNEL, first);
        cfg_write(CFG_MAX_ADJUSTED, cap);
        cfg_write(CFG_CHANNEL_LIMIT, limit);
        cfg_write(CFG_SINGLE_COLOUR, {16'd0, single});
        cfg_release();
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, long hold-off on request
    // ------------------------------------------------------------------

    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            stall = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            // ready stays up until a result goes or a hold-off is asked for
            while (!m_valid && hold_request == 0) @(posedge aclk);
        end
    end

    // every accepted result against the oldest prediction
    always @(posedge aclk) begin : result_check
        cva_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_adjustments.size() == 0) begin
                report_mismatch("result with nothing pending", m_data.out_value, 0);
            end else begin
                want = expected_adjustments.pop_front();
                if (m_data.out_value !== want.out_value)
                    report_mismatch("out_value", m_data.out_value, want.out_value);
                if (m_data.was_adjusted !== want.was_adjusted)
                    report_mismatch("was_adjusted", m_data.was_adjusted, want.was_adjusted);
                if (m_data.fill_all_colours !== want.fill_all_colours)
                    report_mismatch("fill_all_colours", m_data.fill_all_colours,
                                    want.fill_all_colours);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // defaults after reset: every channel selected, mode none passes bytes through
    task automatic test_reset_defaults();
        offer_channel(8'h00, 1'b0);
        offer_channel(8'hFF, 1'b1);
        wait_idle();
    endtask

    // one single-channel frame per mode, bounds at the edges of the datapath
    task automatic mode_case(logic [3:0] mode, int lo, int hi, logic [7:0] value);
        wait_idle();
        load_settings(mode, lo, hi, 17'd1, 17'd1, 17'd0, 17'h10000, mode[0]);
        offer_channel(value, 1'b1);
    endtask

    task automatic test_modes();
        mode_case(MODE_NONE, 0, 0, 8'd200);
        mode_case(MODE_ADD, -1024, 0, 8'd255);            // large negative offset clamps to 0
        mode_case(MODE_PERCENT, -50, 0, 8'd7);            // -3.5 truncates to -3
        mode_case(MODE_FLOOR, 1023, 0, 8'd0);             // floor above a byte clamps to 255
        mode_case(MODE_CEILING, -1024, 0, 8'd255);
        mode_case(MODE_RANGE, 200, 50, 8'd10);            // reversed bounds get swapped
        mode_case(MODE_WRAP_ADD, 100, 0, 8'd200);         // wraps once past 255
        mode_case(MODE_WRAP_PERCENT, 50, 0, 8'd77);       // unfinished mode, pass-through
        mode_case(MODE_AVOID_RANGE, 10, 20, 8'd15);       // tie snaps to the upper bound
        mode_case(MODE_INVERT, 0, 0, 8'd0);
        mode_case(MODE_LAST_CODE, 0, 0, 8'd99);           // unused code acts as none
        wait_idle();
    endtask

    // stride 3 from channel 2, cap of two adjusted, limit above the channel maximum
    task automatic test_channel_selection();
        load_settings(MODE_ADD, 9, 0, 17'd3, 17'd2, 17'd2, 17'h1FFFF, 1'b1);
        for (int i = 0; i < 8; i++) offer_channel(8'($urandom_range(0, 255)), i == 7);
        wait_idle();
    endtask

    // zero stride and zero first channel act as one, first channel rewritten mid-frame
    task automatic test_first_channel_midframe();
        load_settings(MODE_INVERT, 0, 0, 17'd0, 17'd0, 17'd0, 17'd16, 1'b1);
        offer_channel(8'd1, 1'b0);
        offer_channel(8'd2, 1'b0);
        wait_idle();
        // frame already running: the running selection carries on
        cfg_write(CFG_FIRST_CHANNEL, 17'd4);
        cfg_release();
        offer_channel(8'd3, 1'b0);
        offer_channel(8'd4, 1'b1);
        offer_channel(8'd5, 1'b1);     // new frame starts at channel 4, so not selected
        wait_idle();
        // frame not started: the new start applies at once
        cfg_write(CFG_FIRST_CHANNEL, 17'd1);
        cfg_release();
        offer_channel(8'd6, 1'b1);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps going, then the sender waits it out
    task automatic test_backpressure();
        load_settings(MODE_ADD, 37, 0, 17'd2, 17'd1, 17'd0, 17'd40, 1'b0);
        send_gap_max = 0;
        sink_gap_max = 0;
        hold_request = 60;
        for (int i = 0; i < 30; i++) offer_channel(8'($urandom_range(0, 255)), i == 29);
        wait_idle();
        sink_gap_max = 13;
        hold_request = 40;
        for (int i = 0; i < 20; i++) offer_channel(8'($urandom_range(0, 255)), i == 19);
        wait_idle();
        send_gap_max = 13;
    endtask

    // three usable channels: the rest of the frame passes unchanged
    task automatic test_channel_limit();
        load_settings(MODE_INVERT, 0, 0, 17'd1, 17'd1, 17'd0, 17'd3, 1'b0);
        for (int i = 0; i < 6; i++) offer_channel(8'($urandom_range(0, 255)), i == 5);
        wait_idle();
    endtask

    function automatic int draw_level();
        case ($urandom_range(0, 5))
            0:       return int'($urandom_range(0, 2047)) - 1024;
            1:       return $urandom_range(0, 1) ? 1023 : -1024;
            default: return int'($urandom_range(0, 320)) - 40;
        endcase
    endfunction

    // random settings per phase, mostly well-formed frames, some stray frame ends
    task automatic test_random_frames();
        int          sent;
        int          frames;
        int          len;
        logic [3:0]  mode;
        logic [16:0] stride;
        logic [16:0] first;
        logic [16:0] cap;
        logic [16:0] limit;
        sent = 0;
        while (sent < 470) begin
            // previous phase may have left a frame open on purpose
            wait_idle();
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            mode = ($urandom_range(0, 7) == 0)
                   ? 4'($urandom_range(MODE_INVERT + 1, MODE_LAST_CODE))
                   : 4'($urandom_range(MODE_NONE, MODE_INVERT));
            case ($urandom_range(0, 9))
                0:       stride = '0;
                1:       stride = 17'h10000;
                2:       stride = 17'($urandom_range(0, 17'h1FFFF));
                default: stride = 17'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       first = '0;
                1:       first = 17'($urandom_range(0, 17'h1FFFF));
                default: first = 17'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: cap = '0;
                5:             cap = 17'h10000;
                default:       cap = 17'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 9))
                0:       limit = '0;
                1:       limit = 17'h10000;
                2:       limit = 17'($urandom_range(0, 17'h1FFFF));
                default: limit = 17'($urandom_range(1, 40));
            endcase
            load_settings(mode, draw_level(), draw_level(), stride, first, cap, limit,
                          1'($urandom_range(0, 1)));
            frames = $urandom_range(1, 4);
            repeat (frames) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
                for (int i = 0; i < len; i++) begin
                    offer_channel(8'($urandom_range(0, 255)),
                                  (i == len - 1) || ($urandom_range(0, 31) == 0));
                    sent++;
                end
            end
            // sometimes leave a frame open across the next register update
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    offer_channel(8'($urandom_range(0, 255)), 1'b0);
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        // register defaults and cleared counters
        reg_mode       = MODE_NONE;
        reg_first_val  = '0;
        reg_second_val = '0;
        reg_stride     = 17'd1;
        reg_first      = 17'd1;
        reg_cap        = '0;
        reg_limit      = 17'h10000;
        reg_single     = 1'b0;
        chan_pos       = '0;
        next_pick      = '0;
        adj_count      = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_modes();
        test_channel_selection();
        test_first_channel_midframe();
        test_backpressure();
        test_channel_limit();
        test_random_frames();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hang guard, well beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
